/* hw/rtl/lbs_pkg.sv */
package lbs_pkg;

    localparam int QueueDepth = 32;
    localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int QFillW     = $clog2(QueueDepth + 1);
    localparam int EntryW     = 32;

    typedef logic [1:0] t_op;

    localparam t_op OP_SET   = 2'd0;
    localparam t_op OP_BLINK = 2'd1;
    localparam t_op OP_TICK  = 2'd2;

    localparam logic [1:0] CFG_TICK_MS     = 2'd0;
    localparam logic [1:0] CFG_ON_TIME_MS  = 2'd1;
    localparam logic [1:0] CFG_OFF_TIME_MS = 2'd2;

    localparam logic [9:0]  TICK_MS_RST     = 10'd10;
    localparam logic [15:0] ON_TIME_MS_RST  = 16'd250;
    localparam logic [15:0] OFF_TIME_MS_RST = 16'd500;

    typedef struct packed {
        t_op         op;
        logic [23:0] colour;
        logic [7:0]  blinks;
    } t_cmd;

    typedef struct packed {
        logic [9:0]  tick_ms;
        logic [15:0] on_time_ms;
        logic [15:0] off_time_ms;
    } t_cfg;

endpackage

/* hw/rtl/lbs_ram.sv */
module lbs_ram #(
    parameter int Width = 32,
    parameter int Depth = 32,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/lbs_front.sv */
module lbs_front (
    input  logic          start,
    input  lbs_pkg::t_op  i_opcode,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_blinks,
    input  logic          i_q_full,
    output logic          o_busy,
    output logic          o_push,
    output lbs_pkg::t_cmd o_cmd
);
    import lbs_pkg::*;

    logic w_known;

    // unknown opcode is swallowed here and never reaches the back end
    assign w_known = (i_opcode == OP_SET) || (i_opcode == OP_BLINK) || (i_opcode == OP_TICK);

    assign o_busy        = i_q_full;
    assign o_push        = start && !i_q_full && w_known;
    assign o_cmd.op      = i_opcode;
    assign o_cmd.colour  = {i_green, i_red, i_blue};
    assign o_cmd.blinks  = i_blinks;

endmodule

/* hw/rtl/lbs_cmdq.sv */
module lbs_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbs_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output lbs_pkg::t_cmd o_cmd
);
    import lbs_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = i_pop && (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_slot[r_wptr] <= i_cmd;
                r_wptr         <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

/* hw/rtl/lbs_back.sv */
module lbs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lbs_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  lbs_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    output logic [23:0]   o_led_word,
    output logic          o_is_blink_phase
);
    import lbs_pkg::*;

    typedef enum logic {S_IDLE, S_POP} t_state;

    t_state              r_state, n_state;
    logic [23:0]         r_base, n_base;
    logic [23:0]         r_blink, n_blink;
    logic [8:0]          r_phases, n_phases;
    logic [15:0]         r_timer, n_timer;
    logic [QPtrW-1:0]    r_head, n_head;
    logic [QPtrW-1:0]    r_tail, n_tail;
    logic [QFillW-1:0]   r_fill, n_fill;
    logic                r_valid, n_valid;
    logic [23:0]         r_led, n_led;
    logic                r_is_blink, n_is_blink;

    logic                w_we;
    logic [EntryW-1:0]   w_rdata;
    logic                w_on;

    lbs_ram #(.Width(EntryW), .Depth(QueueDepth)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata ({i_cmd.colour, i_cmd.blinks}),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // even phases show the blink colour
    assign w_on = !r_phases[0];

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_blink    = r_blink;
        n_phases   = r_phases;
        n_timer    = r_timer;
        n_head     = r_head;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_valid    = 1'b0;
        n_led      = r_led;
        n_is_blink = r_is_blink;
        w_we       = 1'b0;
        o_cmd_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_SET: begin
                            n_base = i_cmd.colour;
                            if (r_phases == 9'd0 && r_timer == 16'd0) begin
                                n_valid    = 1'b1;
                                n_led      = i_cmd.colour;
                                n_is_blink = 1'b0;
                            end
                        end
                        OP_BLINK: begin
                            if (r_fill < QFillW'(QueueDepth)) begin
                                w_we   = 1'b1;
                                n_tail = (r_tail == QPtrW'(QueueDepth - 1)) ? '0 : r_tail + 1'b1;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (r_timer > {6'd0, i_cfg.tick_ms}) begin
                                n_timer = r_timer - {6'd0, i_cfg.tick_ms};
                            end else if (r_phases != 9'd0) begin
                                n_valid    = 1'b1;
                                n_led      = w_on ? r_blink : r_base;
                                n_is_blink = w_on;
                                n_timer    = w_on ? i_cfg.on_time_ms : i_cfg.off_time_ms;
                                n_phases   = r_phases - 9'd1;
                            end else if (r_fill != '0) begin
                                n_state = S_POP;
                            end else begin
                                n_timer = 16'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_head  = (r_head == QPtrW'(QueueDepth - 1)) ? '0 : r_head + 1'b1;
                n_fill  = r_fill - 1'b1;
                n_state = S_IDLE;
                if (w_rdata[7:0] != 8'd0) begin
                    n_blink    = w_rdata[31:8];
                    n_phases   = {w_rdata[7:0], 1'b0} - 9'd1;
                    n_timer    = i_cfg.on_time_ms;
                    n_valid    = 1'b1;
                    n_led      = w_rdata[31:8];
                    n_is_blink = 1'b1;
                end else begin
                    // zero-count task is dropped
                    n_timer = 16'd0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_base     <= '0;
            r_blink    <= '0;
            r_phases   <= '0;
            r_timer    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_blink    <= n_blink;
            r_phases   <= n_phases;
            r_timer    <= n_timer;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_fill     <= n_fill;
            r_valid    <= n_valid;
        end
        r_led      <= n_led;
        r_is_blink <= n_is_blink;
    end

    assign o_valid          = r_valid;
    assign o_led_word       = r_led;
    assign o_is_blink_phase = r_is_blink;

endmodule

/* hw/rtl/led_blink_sequencer_core.sv */
// led blink sequencer: drives the 24-bit colour word of an rgb led
// command channel: a request is taken at a clock edge with start high and
// busy low; i_opcode selects set base colour, queue blink task or timer tick
// colour fields are packed as green, red, blue into o_led_word
// result channel: o_valid is high for one cycle with o_led_word and
// o_is_blink_phase; the receiver cannot stall, so every strobe is final
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index (0 tick step,
// 1 on time, 2 off time) and i_cfg_data; ready is always high
// a result passes through the command queue and the result register; a tick
// that pulls a task from the task queue also passes through the pop state
// throughput: one request per cycle while busy is low; the back end adds the
// pop state on a tick that pops a task (registered read of the task ram), and
// the two-entry command queue in front absorbs that, raising busy when full
// a full 32-entry task queue drops a new blink task silently
// reset (synchronous, active low) clears colours, phase count, timer, queue
// pointers and the command queue, and loads the default timing registers;
// no clearing pass, task ram contents are only read after being written
module led_blink_sequencer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // command request
    input  logic          start,
    output logic          busy,
    input  lbs_pkg::t_op  i_opcode,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    input  logic [7:0]    i_blinks,
    // result strobe
    output logic          o_valid,
    output logic [23:0]   o_led_word,
    output logic          o_is_blink_phase,
    // config writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import lbs_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    // config register file, writable any cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_ms     <= TICK_MS_RST;
            r_cfg.on_time_ms  <= ON_TIME_MS_RST;
            r_cfg.off_time_ms <= OFF_TIME_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TICK_MS:     r_cfg.tick_ms     <= i_cfg_data[9:0];
                CFG_ON_TIME_MS:  r_cfg.on_time_ms  <= i_cfg_data;
                CFG_OFF_TIME_MS: r_cfg.off_time_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front end: accept and classify requests
    lbs_front u_front (
        .start    (start),
        .i_opcode (i_opcode),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_blinks (i_blinks),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // short command queue decoupling front and back
    lbs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    // back end: colours, phase timer, task queue, result register
    lbs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd_valid      (w_q_valid),
        .i_cmd            (w_q_cmd),
        .o_cmd_pop        (w_q_pop),
        .o_valid          (o_valid),
        .o_led_word       (o_led_word),
        .o_is_blink_phase (o_is_blink_phase)
    );

endmodule

/* hw/rtl/lbs_checker.sv */
module lbs_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input lbs_pkg::t_op i_opcode,
    input logic         o_valid
);
    import lbs_pkg::*;

    // reset leaves no pending result
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // reset empties the command queue
    a_not_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy)
        else $error("busy right after reset");

    // busy only rises after a known command was taken
    a_busy_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy &&
            (i_opcode == OP_SET || i_opcode == OP_BLINK || i_opcode == OP_TICK)))
        else $error("busy rose without an accepted request");

endmodule

bind led_blink_sequencer_core lbs_checker u_lbs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_opcode (i_opcode),
    .o_valid  (o_valid)
);
